// ----- rtl/rls_pkg.sv -----
// Shared types and constants for the run-length stack.
package rls_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned RUN_W  = 2 * WORD_W;  // run entry: value high, count low

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_TOP  = 2'd2,
    OP_SIZE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    STS_OK      = 3'd0,
    STS_FULL    = 3'd1,
    STS_EMPTY   = 3'd2,
    STS_HALTED  = 3'd3,
    STS_NO_ROOM = 3'd4
  } status_t;

endpackage

// ----- rtl/run_length_stack.sv -----
// Run-length stack top level: control sequencer around the run store.
//
// Input stream (s_*): one command per transfer: push, pop, top or size.
// Output stream (m_*): exactly one result per command, in order.
// Config: cfg_wr_en/cfg_wr_data load the capacity (reset: all ones);
// write it only while no command is in flight.
//
// Sequence: a command is taken while idle and resolved in the EXEC state
// once the result register is free; push, top, size and a zero pop end
// there. A nonzero pop walks the runs in the POP state: it reads one run
// store entry per cycle through the single read port while the result
// register is free; a partly consumed run is written back on the last step.
// One command is in flight at a time; s_tready is high only when idle.
// The result register lets the next command be taken while a result
// waits; a new result is held back until m_tready frees that register.
//
// Reset (rst, synchronous) empties the stack and clears the sticky
// failure flag; the run store contents are left as they are.
module run_length_stack
  import rls_pkg::*;
#(
  parameter int unsigned RUN_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // operation[1:0], item_count[33:2], item_value[65:34], 0 pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // status[2:0], read_value[34:3], 0 pad
  output logic        m_tuser,   // read_valid
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);

  localparam int unsigned AW = (RUN_DEPTH > 1) ? $clog2(RUN_DEPTH) : 1;
  localparam int unsigned PW = $clog2(RUN_DEPTH + 1);
  localparam logic [PW-1:0] PTR_FULL = PW'(RUN_DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_POP
  } state_t;

  state_t             state;
  logic [WORD_W-1:0]  capacity;
  logic               failed;
  logic [PW-1:0]      ptr;
  logic [WORD_W:0]    total;
  logic [WORD_W-1:0]  left;

  op_t                op;
  logic [WORD_W-1:0]  op_cnt;
  logic [WORD_W-1:0]  op_val;

  status_t            res_status;
  logic [WORD_W-1:0]  res_value;
  logic               res_valid;

  logic [AW-1:0]      rd_addr;
  logic [AW-1:0]      rd_addr_q;
  logic [RUN_W-1:0]   rd_data;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [RUN_W-1:0]   wr_data;

  logic [PW-1:0]      ptr_m1;
  logic [PW-1:0]      ptr_m2;
  logic [WORD_W:0]    push_sum;
  logic               push_over;
  logic [WORD_W-1:0]  entry_cnt;
  logic [WORD_W-1:0]  entry_val;
  logic [WORD_W-1:0]  left_rem;
  logic               trim;
  logic               out_free;

  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign m_tdata  = {5'd0, res_value, res_status};
  assign m_tuser  = res_valid;

  always_comb begin
    ptr_m1    = ptr - PW'(1);
    ptr_m2    = ptr - PW'(2);
    push_sum  = total + {1'b0, op_cnt};
    push_over = push_sum > {1'b0, capacity};
    entry_cnt = rd_data[WORD_W-1:0];
    entry_val = rd_data[RUN_W-1:WORD_W];
    left_rem  = left - entry_cnt;
    trim      = entry_cnt > left;

    rd_addr = rd_addr_q;
    wr_en   = 1'b0;
    wr_addr = ptr[AW-1:0];
    wr_data = {op_val, op_cnt};
    unique case (state)
      ST_IDLE: begin
        // prefetch the top run for top and pop
        rd_addr = ptr_m1[AW-1:0];
      end
      ST_EXEC: begin
        if (out_free && !failed && op == OP_PUSH && !push_over && ptr != PTR_FULL) begin
          wr_en = 1'b1;
        end
      end
      ST_POP: begin
        if (out_free) begin
          if (trim) begin
            wr_en   = 1'b1;
            wr_addr = ptr_m1[AW-1:0];
            wr_data = {entry_val, entry_cnt - left};
          end else begin
            rd_addr = ptr_m2[AW-1:0];
          end
        end
      end
      default: ;
    endcase
  end

  rls_run_mem #(
    .DEPTH (RUN_DEPTH),
    .AW    (AW)
  ) u_run_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    rd_addr_q <= rd_addr;
    if (rst) begin
      capacity <= '1;
    end else if (cfg_wr_en) begin
      capacity <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      failed   <= 1'b0;
      ptr      <= '0;
      total    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            op     <= op_t'(s_tdata[1:0]);
            op_cnt <= s_tdata[33:2];
            op_val <= s_tdata[65:34];
            state  <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (out_free) begin
            res_status <= STS_OK;
            res_value  <= '0;
            res_valid  <= 1'b0;
            m_tvalid   <= 1'b1;
            state      <= ST_IDLE;
            if (failed) begin
              res_status <= STS_HALTED;
            end else begin
              case (op)
                OP_PUSH: begin
                  if (push_over) begin
                    res_status <= STS_FULL;
                    failed     <= 1'b1;
                  end else if (ptr == PTR_FULL) begin
                    res_status <= STS_NO_ROOM;
                    failed     <= 1'b1;
                  end else begin
                    ptr   <= ptr + PW'(1);
                    total <= push_sum;
                  end
                end
                OP_POP: begin
                  if ({1'b0, op_cnt} > total) begin
                    res_status <= STS_EMPTY;
                    failed     <= 1'b1;
                  end else if (op_cnt != '0) begin
                    // walk runs from the top; result comes at the end
                    total    <= total - {1'b0, op_cnt};
                    left     <= op_cnt;
                    m_tvalid <= 1'b0;
                    state    <= ST_POP;
                  end
                end
                OP_TOP: begin
                  if (ptr == '0) begin
                    res_status <= STS_EMPTY;
                    failed     <= 1'b1;
                  end else begin
                    res_value <= entry_val;
                    res_valid <= 1'b1;
                  end
                end
                default: begin
                  res_value <= total[WORD_W-1:0];
                  res_valid <= 1'b1;
                end
              endcase
            end
          end
        end
        ST_POP: begin
          if (out_free) begin
            if (trim) begin
              res_status <= STS_OK;
              res_value  <= '0;
              res_valid  <= 1'b0;
              m_tvalid   <= 1'b1;
              state      <= ST_IDLE;
            end else begin
              ptr  <= ptr_m1;
              left <= left_rem;
              if (left_rem == '0) begin
                res_status <= STS_OK;
                res_value  <= '0;
                res_valid  <= 1'b0;
                m_tvalid   <= 1'b1;
                state      <= ST_IDLE;
              end
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/rls_run_mem.sv -----
// Run store: single write port, one registered read port.
module rls_run_mem
  import rls_pkg::*;
#(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [RUN_W-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [RUN_W-1:0] rd_data
);

  logic [RUN_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- bench/tb_top.sv -----
// Self-checking bench for run_length_stack: directed, capacity, deep-store, random, sticky traffic.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rls_pkg::*;

  localparam int unsigned DEPTH = 256;
  localparam int unsigned CYCLE_LIMIT = 1_200_000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned RANDOM_PHASES = 6;
  localparam int unsigned PHASE_ITEMS = 125;

  typedef enum int {
    FAIL_FULL,
    FAIL_NO_ROOM,
    FAIL_POP_EMPTY,
    FAIL_TOP_EMPTY,
    FAIL_ZERO_CAP
  } fail_kind_t;

  typedef struct {
    status_t     status;
    logic [31:0] value;
    logic        valid;
  } stack_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        m_tuser;
  logic        cfg_wr_en = 1'b0;
  logic [31:0] cfg_wr_data = '0;

  // shadow copy of the stack
  logic [31:0] run_val [DEPTH];
  logic [31:0] run_cnt [DEPTH];
  int unsigned runs_held = 0;
  logic [32:0] items_held = '0;
  logic        stuck = 1'b0;
  logic [31:0] capacity = '1;

  stack_result_t pending_results[$];
  stack_result_t want;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;
  int unsigned stall_mode = 0;
  int unsigned stall_left = 0;

  run_length_stack #(.RUN_DEPTH(DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(string what);
    $display("tb_top: mismatch at cycle %0d: %s", cycle_count, what);
    error_count++;
  endtask

  // Applies one command to the shadow stack and queues the result it must give.
  function automatic void predict_command(op_t op, logic [31:0] cnt, logic [31:0] val);
    stack_result_t r;
    logic [31:0] left;
    r.status = STS_OK;
    r.value = '0;
    r.valid = 1'b0;
    if (stuck) begin
      r.status = STS_HALTED;
    end else begin
      case (op)
        OP_PUSH: begin
          if (items_held + {1'b0, cnt} > {1'b0, capacity}) begin
            r.status = STS_FULL;
            stuck = 1'b1;
          end else if (runs_held >= DEPTH) begin
            r.status = STS_NO_ROOM;
            stuck = 1'b1;
          end else begin
            run_val[runs_held] = val;
            run_cnt[runs_held] = cnt;
            runs_held++;
            items_held = items_held + {1'b0, cnt};
          end
        end
        OP_POP: begin
          if ({1'b0, cnt} > items_held) begin
            r.status = STS_EMPTY;
            stuck = 1'b1;
          end else begin
            items_held = items_held - {1'b0, cnt};
            left = cnt;
            // zero-count runs are dropped as the walk passes them
            while (left != 0 && runs_held > 0) begin
              if (run_cnt[runs_held - 1] > left) begin
                run_cnt[runs_held - 1] = run_cnt[runs_held - 1] - left;
                left = '0;
              end else begin
                left = left - run_cnt[runs_held - 1];
                runs_held--;
              end
            end
          end
        end
        OP_TOP: begin
          if (runs_held == 0) begin
            r.status = STS_EMPTY;
            stuck = 1'b1;
          end else begin
            r.value = run_val[runs_held - 1];
            r.valid = 1'b1;
          end
        end
        default: begin
          r.value = items_held[31:0];
          r.valid = 1'b1;
        end
      endcase
    end
    pending_results.push_back(r);
  endfunction

  // Sender works in bursts; valid is only dropped at the start of a gap.
  task automatic send_command(op_t op, logic [31:0] cnt, logic [31:0] val);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      burst_left = $urandom_range(1, 24);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    predict_command(op, cnt, val);
    s_tvalid <= 1'b1;
    s_tdata <= {6'b0, val, cnt, op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    burst_left--;
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_capacity(logic [31:0] v);
    drain_results();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    capacity = v;
  endtask

  // Field extremes, every operation, zero-count runs and multi-run pops.
  task automatic test_directed_ops();
    send_command(OP_SIZE, 32'd0, 32'd0);
    send_command(OP_POP, 32'd0, 32'hFFFF_FFFF);
    send_command(OP_PUSH, 32'hFFFF_FFFF, 32'd0);
    send_command(OP_SIZE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_command(OP_PUSH, 32'd0, 32'hFFFF_FFFF);
    send_command(OP_TOP, 32'd0, 32'd0);
    send_command(OP_POP, 32'hFFFF_FFFF, 32'd0);
    send_command(OP_SIZE, 32'd0, 32'd0);
    send_command(OP_PUSH, 32'd5, 32'hA5A5_A5A5);
    send_command(OP_PUSH, 32'd0, 32'h5A5A_5A5A);
    send_command(OP_POP, 32'd2, 32'd0);
    send_command(OP_TOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_command(OP_POP, 32'd0, 32'd0);
    send_command(OP_PUSH, 32'd4, 32'd0);
    send_command(OP_SIZE, 32'd0, 32'd0);
  endtask

  // Capacity dropped to zero under a loaded stack, then restored.
  task automatic test_capacity_extremes();
    set_capacity(32'd0);
    send_command(OP_SIZE, 32'd0, 32'd0);
    send_command(OP_TOP, 32'd0, 32'd0);
    send_command(OP_POP, 32'd1, 32'd0);
    send_command(OP_SIZE, 32'd0, 32'd0);
    set_capacity('1);
    send_command(OP_POP, items_held[31:0], 32'd0);
    send_command(OP_SIZE, 32'd0, 32'd0);
  endtask

  // Fill every run slot, then pop across all of them in one command.
  task automatic test_deep_store();
    logic [31:0] cnt;
    while (runs_held < DEPTH) begin
      cnt = (items_held == 0) ? $urandom_range(1, 3) : $urandom_range(0, 3);
      send_command(OP_PUSH, cnt, $urandom);
    end
    send_command(OP_TOP, $urandom, $urandom);
    send_command(OP_SIZE, $urandom, $urandom);
    send_command(OP_POP, items_held[31:0], $urandom);
    send_command(OP_SIZE, 32'd0, 32'd0);
  endtask

  // Only commands that keep the stack alive; a zero-count run never lands on an empty stack.
  task automatic random_command();
    int unsigned pick;
    logic [31:0] held;
    logic [31:0] room;
    logic [31:0] cnt;
    pick = $urandom_range(0, 99);
    held = items_held[31:0];
    room = (items_held <= {1'b0, capacity}) ? capacity - held : 32'd0;
    if (pick < 45 && items_held <= {1'b0, capacity} && runs_held < DEPTH &&
        (held != 0 || room != 0)) begin
      case ($urandom_range(0, 9))
        0: cnt = $urandom_range(0, room);
        1: cnt = 32'd0;
        default: cnt = $urandom_range(0, (room < 6) ? room : 6);
      endcase
      if (held == 0 && cnt == 0) cnt = 32'd1;
      send_command(OP_PUSH, cnt, $urandom);
    end else if (pick < 70) begin
      case ($urandom_range(0, 9))
        0: cnt = held;
        1: cnt = $urandom_range(0, held);
        default: cnt = $urandom_range(0, (held < 8) ? held : 8);
      endcase
      send_command(OP_POP, cnt, $urandom);
    end else if (pick < 85 && runs_held != 0) begin
      send_command(OP_TOP, $urandom, $urandom);
    end else begin
      send_command(OP_SIZE, $urandom, $urandom);
    end
  endtask

  task automatic test_random_traffic();
    logic [31:0] v;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case ($urandom_range(0, 4))
        0: v = '1;
        1: v = $urandom;
        2: v = items_held[31:0];
        3: v = (items_held[31:0] > 32'hFFFF_FF00) ? 32'hFFFF_FFFF :
               items_held[31:0] + $urandom_range(0, 64);
        default: v = items_held[31:0] >> 1;
      endcase
      set_capacity(v);
      repeat (PHASE_ITEMS) random_command();
    end
  endtask

  // One failure per run (reset is never repeated), then halted traffic.
  task automatic test_sticky_failure();
    fail_kind_t kind;
    kind = fail_kind_t'($urandom_range(0, 4));
    case (kind)
      FAIL_FULL: begin
        set_capacity(items_held[31:0]);
        send_command(OP_PUSH, $urandom_range(1, 32'hFFFF_FFFF), $urandom);
      end
      FAIL_NO_ROOM: begin
        set_capacity('1);
        while (runs_held < DEPTH)
          send_command(OP_PUSH, (items_held == 0) ? 32'd1 : 32'd0, $urandom);
        send_command(OP_PUSH, $urandom_range(0, 16), $urandom);
      end
      FAIL_POP_EMPTY: begin
        if (items_held != 0) send_command(OP_POP, items_held[31:0], $urandom);
        send_command(OP_POP, $urandom_range(1, 32'hFFFF_FFFF), $urandom);
      end
      FAIL_TOP_EMPTY: begin
        if (items_held != 0) send_command(OP_POP, items_held[31:0], $urandom);
        send_command(OP_TOP, $urandom, $urandom);
      end
      default: begin
        set_capacity(32'd0);
        send_command(OP_PUSH, (items_held == 0) ? $urandom_range(1, 32'hFFFF_FFFF) : $urandom,
                     $urandom);
      end
    endcase
    repeat (12) send_command(op_t'($urandom_range(0, 3)), $urandom, $urandom);
  endtask

  // Receiver: stretches of always-ready, random, and mostly-stalled.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(5, 40);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= $urandom_range(0, 1);
      default: m_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid === 1'b1 && m_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result transfer with no command pending");
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[2:0] !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", m_tdata[2:0], want.status));
        if (m_tdata[34:3] !== want.value)
          report_mismatch($sformatf("read_value %h, expected %h", m_tdata[34:3], want.value));
        if (m_tuser !== want.valid)
          report_mismatch($sformatf("read_valid %b, expected %b", m_tuser, want.valid));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed_ops();
    test_capacity_extremes();
    test_deep_store();
    test_random_traffic();
    test_sticky_failure();
    drain_results();
    if (error_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

// ----- run_length_stack.f -----
rtl/rls_pkg.sv
rtl/rls_run_mem.sv
rtl/run_length_stack.sv
bench/tb_top.sv
